// ===== rtl/jet_pkg.sv =====
// Shared types and constants for the Julia escape-time block.
// Used by the channel interfaces, the mapping stage, the iteration ring and the top level.
// No dependencies.
package jet_pkg;

    // Field widths fixed by the block's data format.
    localparam int PIXEL_BITS = 12;
    localparam int REG_BITS   = 32;
    localparam int CNT_BITS   = 8;
    localparam int WIDE_BITS  = 2 * REG_BITS;
    localparam int TAG_BITS   = 2;
    localparam int IDX_BITS   = 3;

    // Hard cap on the iteration count, applied on top of max_iterations.
    localparam int ITER_LIMIT = 255;

    typedef logic [PIXEL_BITS-1:0]       t_pix;
    typedef logic signed [REG_BITS-1:0]  t_fix;
    typedef logic signed [WIDE_BITS-1:0] t_wide;
    typedef logic [CNT_BITS-1:0]         t_cnt;
    typedef logic [TAG_BITS-1:0]         t_tag;

    // Configuration register indexes.
    typedef enum logic [IDX_BITS-1:0] {
        REG_C_REAL   = 3'd0,
        REG_C_IMAG   = 3'd1,
        REG_X_STEP   = 3'd2,
        REG_X_OFFSET = 3'd3,
        REG_Y_STEP   = 3'd4,
        REG_Y_OFFSET = 3'd5,
        REG_MAX_ITER = 3'd6
    } t_reg_idx;

    // Settings seen by the coordinate mapping stage.
    typedef struct packed {
        t_fix x_step;
        t_fix x_offset;
        t_fix y_step;
        t_fix y_offset;
        t_cnt limit;
    } t_map_cfg;

    // A mapped pixel waiting to enter the iteration ring.
    typedef struct packed {
        t_pix px;
        t_pix py;
        t_fix zr;
        t_fix zi;
        t_cnt limit;
    } t_start;

    // One slot of the iteration ring.
    typedef struct packed {
        logic valid;
        logic done;
        t_tag tag;
        t_pix px;
        t_pix py;
        t_fix zr;
        t_fix zi;
        t_cnt count;
        t_cnt limit;
    } t_tok;

    // A finished pixel leaving the ring.
    typedef struct packed {
        t_pix px;
        t_pix py;
        t_cnt count;
    } t_done;

endpackage

// ===== rtl/jet_pix_if.sv =====
// Pixel input channel: valid/ready handshake with the pixel coordinates.
// Depends on jet_pkg for the coordinate type.
interface jet_pix_if;
    import jet_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_x;
    t_pix pixel_y;

    modport source(output valid, output pixel_x, output pixel_y, input ready);
    modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/jet_res_if.sv =====
// Result output channel: valid/ready handshake with the pixel and its escape count.
// Depends on jet_pkg for the coordinate and count types.
interface jet_res_if;
    import jet_pkg::*;

    logic valid;
    logic ready;
    t_pix out_x;
    t_pix out_y;
    t_cnt iteration_count;

    modport source(output valid, output out_x, output out_y, output iteration_count,
                   input ready);
    modport sink(input valid, input out_x, input out_y, input iteration_count,
                 output ready);
endinterface

// ===== rtl/jet_map.sv =====
// Front stage: maps an incoming pixel to its complex start value and holds it
// until the iteration ring has a free slot. Depends on jet_pkg and jet_pix_if.
module jet_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jet_pix_if.sink           s_pix,
    input  jet_pkg::t_map_cfg i_cfg,
    output logic              o_valid,
    output jet_pkg::t_start   o_start,
    input  logic              i_take
);
    import jet_pkg::*;

    logic   r_valid;
    t_start r_start;
    t_start n_start;
    t_fix   prod_x;
    t_fix   prod_y;
    logic   accept;

    // The stage refills in the same cycle that the ring takes its beat.
    assign s_pix.ready = !r_valid || i_take;
    assign accept      = s_pix.valid && s_pix.ready;

    // Start value: pixel times step plus offset, wrapped to 32 bits.
    assign prod_x = t_fix'($signed({1'b0, s_pix.pixel_x}) * i_cfg.x_step);
    assign prod_y = t_fix'($signed({1'b0, s_pix.pixel_y}) * i_cfg.y_step);

    always_comb begin
        n_start.px    = s_pix.pixel_x;
        n_start.py    = s_pix.pixel_y;
        n_start.zr    = prod_x + i_cfg.x_offset;
        n_start.zi    = prod_y + i_cfg.y_offset;
        n_start.limit = i_cfg.limit;
    end

    // Holding register and its valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start <= n_start;
        end
    end

    assign o_valid = r_valid;
    assign o_start = r_start;
endmodule

// ===== rtl/jet_ring.sv =====
// Iteration ring: three register stages (square, escape test and update, add c)
// that pixels circulate through, one iteration per trip. Depends on jet_pkg.
module jet_ring #(
    parameter int FRAC_BITS = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start_valid,
    input  jet_pkg::t_start i_start,
    output logic            o_take,
    input  jet_pkg::t_fix   i_c_real,
    input  jet_pkg::t_fix   i_c_imag,
    input  logic            i_out_free,
    output logic            o_ret_valid,
    output jet_pkg::t_done  o_ret
);
    import jet_pkg::*;

    // Escape threshold 4.0 at twice the fraction width.
    localparam logic [WIDE_BITS-1:0] FOUR = WIDE_BITS'(1) << (2 * FRAC_BITS + 2);

    t_tok  r_a;
    t_tok  n_a;
    t_tok  r_b;
    t_wide r_rr;
    t_wide r_ii;
    t_wide r_ri;
    t_wide n_rr;
    t_wide n_ii;
    t_wide n_ri;
    t_tok  r_c;
    t_tok  n_c;
    logic  r_add_c;
    logic  n_add_c;
    t_tag  r_iss_tag;
    t_tag  r_ret_tag;

    t_tok                 head;
    logic                 retire;
    logic                 slot_free;
    logic [WIDE_BITS-1:0] mag;
    logic                 esc;
    t_wide                diff;
    t_wide                diff_sh;
    t_wide                ri_sh;

    // Stage A to B: the two squares and the cross product.
    assign n_rr = r_a.zr * r_a.zr;
    assign n_ii = r_a.zi * r_a.zi;
    assign n_ri = r_a.zr * r_a.zi;

    // Stage B to C: escape test and the shifted new z, without c yet.
    assign mag     = unsigned'(r_rr) + unsigned'(r_ii);
    assign esc     = (r_b.count >= r_b.limit) || (mag >= FOUR);
    assign diff    = r_rr - r_ii;
    assign diff_sh = diff >>> FRAC_BITS;
    assign ri_sh   = r_ri >>> (FRAC_BITS - 1);

    always_comb begin
        n_c     = r_b;
        n_add_c = 1'b0;
        if (r_b.valid && !r_b.done) begin
            if (esc) begin
                n_c.done = 1'b1;
            end else begin
                n_c.zr    = diff_sh[REG_BITS-1:0];
                n_c.zi    = ri_sh[REG_BITS-1:0];
                n_c.count = r_b.count + 1'b1;
                n_add_c   = 1'b1;
            end
        end
    end

    // Ring head: finish the update, retire in order, then insert a new pixel.
    always_comb begin
        head = r_c;
        if (r_add_c) begin
            head.zr = r_c.zr + i_c_real;
            head.zi = r_c.zi + i_c_imag;
        end
    end

    assign retire    = head.valid && head.done && (head.tag == r_ret_tag) && i_out_free;
    assign slot_free = !head.valid || retire;
    assign o_take    = slot_free && i_start_valid;

    always_comb begin
        n_a = head;
        if (retire) begin
            n_a.valid = 1'b0;
        end
        if (o_take) begin
            n_a.valid = 1'b1;
            n_a.done  = 1'b0;
            n_a.tag   = r_iss_tag;
            n_a.px    = i_start.px;
            n_a.py    = i_start.py;
            n_a.zr    = i_start.zr;
            n_a.zi    = i_start.zi;
            n_a.count = '0;
            n_a.limit = i_start.limit;
        end
    end

    // Valid bits and order tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_add_c   <= 1'b0;
            r_iss_tag <= '0;
            r_ret_tag <= '0;
        end else begin
            r_a.valid <= n_a.valid;
            r_b.valid <= r_a.valid;
            r_c.valid <= n_c.valid;
            r_add_c   <= n_add_c;
            if (o_take) begin
                r_iss_tag <= r_iss_tag + 1'b1;
            end
            if (retire) begin
                r_ret_tag <= r_ret_tag + 1'b1;
            end
        end

        // Slot payload moves every cycle.
        r_a.done  <= n_a.done;
        r_a.tag   <= n_a.tag;
        r_a.px    <= n_a.px;
        r_a.py    <= n_a.py;
        r_a.zr    <= n_a.zr;
        r_a.zi    <= n_a.zi;
        r_a.count <= n_a.count;
        r_a.limit <= n_a.limit;
        r_b.done  <= r_a.done;
        r_b.tag   <= r_a.tag;
        r_b.px    <= r_a.px;
        r_b.py    <= r_a.py;
        r_b.zr    <= r_a.zr;
        r_b.zi    <= r_a.zi;
        r_b.count <= r_a.count;
        r_b.limit <= r_a.limit;
        r_rr      <= n_rr;
        r_ii      <= n_ii;
        r_ri      <= n_ri;
        r_c.done  <= n_c.done;
        r_c.tag   <= n_c.tag;
        r_c.px    <= n_c.px;
        r_c.py    <= n_c.py;
        r_c.zr    <= n_c.zr;
        r_c.zi    <= n_c.zi;
        r_c.count <= n_c.count;
        r_c.limit <= n_c.limit;
    end

    assign o_ret_valid = retire;
    assign o_ret.px    = head.px;
    assign o_ret.py    = head.py;
    assign o_ret.count = head.count;
endmodule

// ===== rtl/julia_escape_time.sv =====
// Top level of the Julia escape-time block: configuration registers, mapping
// stage, iteration ring and output register. Depends on jet_pkg, both channel
// interfaces, jet_map and jet_ring.

// Each pixel beat is mapped to its start value z and registered, then enters a
// three-stage iteration ring where one trip round the ring is one z = z^2 + c
// step. The ring holds up to three pixels at once, interleaved, and results
// leave strictly in input order, so a pixel that escapes early waits in the
// ring behind an older one that is still iterating. Sustained throughput is
// therefore set by the ring. The user must write the configuration registers
// only while idle; the block itself does not enforce this.
module julia_escape_time #(
    parameter int FRAC_BITS = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jet_pix_if.sink                       i_pix,
    jet_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [jet_pkg::IDX_BITS-1:0]  i_cfg_idx,
    input  logic [jet_pkg::REG_BITS-1:0]  i_cfg_data
);
    import jet_pkg::*;

    t_fix     r_c_real;
    t_fix     r_c_imag;
    t_fix     r_x_step;
    t_fix     r_x_offset;
    t_fix     r_y_step;
    t_fix     r_y_offset;
    t_cnt     r_max_iter;
    t_map_cfg map_cfg;
    t_cnt     limit;

    logic   start_valid;
    t_start start;
    logic   start_take;
    logic   out_free;
    logic   ret_valid;
    t_done  ret;
    logic   r_out_valid;
    t_done  r_out;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real   <= '0;
            r_c_imag   <= '0;
            r_x_step   <= t_fix'(335544);
            r_x_offset <= t_fix'(-134217728);
            r_y_step   <= t_fix'(335544);
            r_y_offset <= t_fix'(-134217728);
            r_max_iter <= t_cnt'(255);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_C_REAL:   r_c_real   <= i_cfg_data;
                REG_C_IMAG:   r_c_imag   <= i_cfg_data;
                REG_X_STEP:   r_x_step   <= i_cfg_data;
                REG_X_OFFSET: r_x_offset <= i_cfg_data;
                REG_Y_STEP:   r_y_step   <= i_cfg_data;
                REG_Y_OFFSET: r_y_offset <= i_cfg_data;
                REG_MAX_ITER: r_max_iter <= i_cfg_data[CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective loop bound, capped at the hard iteration limit.
    assign limit = (int'(r_max_iter) > ITER_LIMIT) ? t_cnt'(ITER_LIMIT) : r_max_iter;

    always_comb begin
        map_cfg.x_step   = r_x_step;
        map_cfg.x_offset = r_x_offset;
        map_cfg.y_step   = r_y_step;
        map_cfg.y_offset = r_y_offset;
        map_cfg.limit    = limit;
    end

    jet_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_pix   (i_pix),
        .i_cfg   (map_cfg),
        .o_valid (start_valid),
        .o_start (start),
        .i_take  (start_take)
    );

    jet_ring #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_valid (start_valid),
        .i_start       (start),
        .o_take        (start_take),
        .i_c_real      (r_c_real),
        .i_c_imag      (r_c_imag),
        .i_out_free    (out_free),
        .o_ret_valid   (ret_valid),
        .o_ret         (ret)
    );

    // Output register; the ring keeps iterating while a result waits here.
    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ret_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ret_valid) begin
            r_out <= ret;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.out_x           = r_out.px;
    assign o_res.out_y           = r_out.py;
    assign o_res.iteration_count = r_out.count;

    // A pixel only leaves the ring when the output register can take it.
    a_retire_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ret_valid |-> out_free)
        else $error("ring retired a pixel into a full output register");

    // The ring only takes a mapped pixel that is actually there.
    a_take_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_take |-> start_valid)
        else $error("ring took a start value from an empty mapping stage");

    // A retired pixel shows up as a valid result in the next cycle.
    a_retire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ret_valid |=> o_res.valid)
        else $error("retired pixel did not reach the output");
endmodule
